// ----- design/wsd_pkg.sv -----
// wsd_pkg: shared types and constants for the websocket frame deframer
// no dependencies
`timescale 1ns / 1ps

package wsd_pkg;

    localparam int BYTE_W = 8;
    localparam int LEN_W  = 16;
    localparam int STAT_W = 3;
    localparam int OPC_W  = 4;

    localparam logic [LEN_W-1:0] MAX_PAYLOAD_RESET = 16'd256;

    // result status codes
    localparam logic [STAT_W-1:0] ST_DATA   = 3'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY  = 3'd1;
    localparam logic [STAT_W-1:0] ST_CLOSE  = 3'd2;
    localparam logic [STAT_W-1:0] ST_NOMASK = 3'd3;
    localparam logic [STAT_W-1:0] ST_LEN64  = 3'd4;
    localparam logic [STAT_W-1:0] ST_BIG    = 3'd5;
    localparam logic [STAT_W-1:0] ST_BADOP  = 3'd6;

    // header constants
    localparam logic [OPC_W-1:0] OPC_CLOSE    = 4'h8;
    localparam logic [OPC_W-1:0] OPC_LAST_DATA = 4'h2;
    localparam logic [6:0]       LEN_EXT16    = 7'd126;

    typedef struct packed {
        logic [BYTE_W-1:0] payload_byte;
        logic [STAT_W-1:0] status;
        logic              fin_flag;
        logic [OPC_W-1:0]  frame_opcode;
        logic [LEN_W-1:0]  frame_length;
        logic              last_of_frame;
    } result_t;

endpackage

// ----- design/wsd_if.sv -----
// wsd channel interfaces: received byte, result item and config write
// depends on wsd_pkg
`timescale 1ns / 1ps

interface wsd_byte_if;
    logic                         valid;
    logic                         ready;
    logic [wsd_pkg::BYTE_W-1:0]   data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink (input valid, input data_byte, output ready);
endinterface

interface wsd_result_if;
    logic                         valid;
    logic                         ready;
    logic [wsd_pkg::BYTE_W-1:0]   payload_byte;
    logic [wsd_pkg::STAT_W-1:0]   status;
    logic                         fin_flag;
    logic [wsd_pkg::OPC_W-1:0]    frame_opcode;
    logic [wsd_pkg::LEN_W-1:0]    frame_length;
    logic                         last_of_frame;

    modport source (output valid, output payload_byte, output status, output fin_flag,
                    output frame_opcode, output frame_length, output last_of_frame,
                    input ready);
    modport sink (input valid, input payload_byte, input status, input fin_flag,
                  input frame_opcode, input frame_length, input last_of_frame,
                  output ready);
endinterface

interface wsd_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [wsd_pkg::LEN_W-1:0]    max_payload;

    modport source (output valid, output max_payload, input ready);
    modport sink (input valid, input max_payload, output ready);
endinterface

// ----- design/wsd_in_stage.sv -----
// wsd_in_stage: input register for received bytes
// depends on wsd_pkg and wsd_byte_if
`timescale 1ns / 1ps

module wsd_in_stage (
    input  logic                        clk,
    input  logic                        rst_n,
    wsd_byte_if.sink                    rx,
    input  logic                        advance,
    output logic                        item_valid,
    output logic [wsd_pkg::BYTE_W-1:0]  item_byte
);

    logic                       valid_reg;
    logic                       valid_next;
    logic [wsd_pkg::BYTE_W-1:0] byte_reg;

    assign rx.ready = !valid_reg || advance;

    always_comb
    begin
        valid_next = valid_reg;
        if (rx.ready)
        begin
            valid_next = rx.valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx.valid && rx.ready)
        begin
            byte_reg <= rx.data_byte;
        end
    end

    assign item_valid = valid_reg;
    assign item_byte  = byte_reg;

endmodule

// ----- design/wsd_parser.sv -----
// wsd_parser: frame header state machine, mask key store and payload unmasking
// depends on wsd_pkg
`timescale 1ns / 1ps

module wsd_parser (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        advance,
    input  logic [wsd_pkg::BYTE_W-1:0]  item_byte,
    input  logic [wsd_pkg::LEN_W-1:0]   max_payload,
    output logic                        result_valid,
    output wsd_pkg::result_t            result
);

    localparam logic [2:0] PH_HDR0  = 3'd0;
    localparam logic [2:0] PH_HDR1  = 3'd1;
    localparam logic [2:0] PH_EXTHI = 3'd2;
    localparam logic [2:0] PH_EXTLO = 3'd3;
    localparam logic [2:0] PH_MASK  = 3'd4;
    localparam logic [2:0] PH_DATA  = 3'd5;
    localparam logic [2:0] PH_HALT  = 3'd6;

    logic [2:0]                  phase_reg, phase_next;
    logic                        fin_reg, fin_next;
    logic [wsd_pkg::OPC_W-1:0]   opcode_reg, opcode_next;
    logic [wsd_pkg::LEN_W-1:0]   length_reg, length_next;
    logic [wsd_pkg::LEN_W-1:0]   byte_count_reg, byte_count_next;
    logic [1:0]                  sub_index_reg, sub_index_next;
    logic [wsd_pkg::BYTE_W-1:0]  mask_key_reg [4];
    logic                        key_write;

    logic [wsd_pkg::LEN_W-1:0]   count_inc;
    logic                        is_data_op;
    logic                        frame_last;
    logic [wsd_pkg::STAT_W-1:0]  end_status;
    logic [wsd_pkg::STAT_W-1:0]  status_c;
    logic [wsd_pkg::BYTE_W-1:0]  payload_c;
    logic                        last_c;

    assign count_inc  = byte_count_reg + 16'd1;
    assign frame_last = (count_inc == length_reg);
    assign is_data_op = (opcode_reg <= wsd_pkg::OPC_LAST_DATA);
    assign end_status = (opcode_reg == wsd_pkg::OPC_CLOSE) ? wsd_pkg::ST_CLOSE
                                                           : wsd_pkg::ST_BADOP;

    always_comb
    begin
        phase_next      = phase_reg;
        fin_next        = fin_reg;
        opcode_next     = opcode_reg;
        length_next     = length_reg;
        byte_count_next = byte_count_reg;
        sub_index_next  = sub_index_reg;
        key_write       = 1'b0;
        result_valid    = 1'b0;
        status_c        = wsd_pkg::ST_DATA;
        payload_c       = '0;
        last_c          = 1'b0;
        if (advance)
        begin
            unique case (phase_reg)
                PH_HDR0:
                begin
                    fin_next        = item_byte[7];
                    opcode_next     = item_byte[3:0];
                    length_next     = '0;
                    byte_count_next = '0;
                    phase_next      = PH_HDR1;
                end
                PH_HDR1:
                begin
                    if (!item_byte[7])
                    begin
                        phase_next   = PH_HALT;
                        result_valid = 1'b1;
                        status_c     = wsd_pkg::ST_NOMASK;
                        last_c       = 1'b1;
                    end
                    else if (item_byte[6:0] < wsd_pkg::LEN_EXT16)
                    begin
                        length_next = {9'd0, item_byte[6:0]};
                        if (length_next > max_payload)
                        begin
                            phase_next   = PH_HALT;
                            result_valid = 1'b1;
                            status_c     = wsd_pkg::ST_BIG;
                            last_c       = 1'b1;
                        end
                        else
                        begin
                            sub_index_next = '0;
                            phase_next     = PH_MASK;
                        end
                    end
                    else if (item_byte[6:0] == wsd_pkg::LEN_EXT16)
                    begin
                        phase_next = PH_EXTHI;
                    end
                    else
                    begin
                        phase_next   = PH_HALT;
                        result_valid = 1'b1;
                        status_c     = wsd_pkg::ST_LEN64;
                        last_c       = 1'b1;
                    end
                end
                PH_EXTHI:
                begin
                    length_next = {item_byte, 8'd0};
                    phase_next  = PH_EXTLO;
                end
                PH_EXTLO:
                begin
                    length_next = {length_reg[15:8], item_byte};
                    if (length_next > max_payload)
                    begin
                        phase_next   = PH_HALT;
                        result_valid = 1'b1;
                        status_c     = wsd_pkg::ST_BIG;
                        last_c       = 1'b1;
                    end
                    else
                    begin
                        sub_index_next = '0;
                        phase_next     = PH_MASK;
                    end
                end
                PH_MASK:
                begin
                    key_write      = 1'b1;
                    sub_index_next = sub_index_reg + 2'd1;
                    if (sub_index_reg == 2'd3)
                    begin
                        byte_count_next = '0;
                        if (length_reg == '0)
                        begin
                            result_valid = 1'b1;
                            last_c       = 1'b1;
                            if (is_data_op)
                            begin
                                phase_next = PH_HDR0;
                                status_c   = wsd_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                phase_next = PH_HALT;
                                status_c   = end_status;
                            end
                        end
                        else
                        begin
                            phase_next = PH_DATA;
                        end
                    end
                end
                PH_DATA:
                begin
                    byte_count_next = count_inc;
                    if (is_data_op)
                    begin
                        result_valid = 1'b1;
                        payload_c    = item_byte ^ mask_key_reg[byte_count_reg[1:0]];
                        last_c       = frame_last;
                        if (frame_last)
                        begin
                            phase_next = PH_HDR0;
                        end
                    end
                    else if (frame_last)
                    begin
                        phase_next   = PH_HALT;
                        result_valid = 1'b1;
                        status_c     = end_status;
                        last_c       = 1'b1;
                    end
                end
                default:
                begin
                    phase_next = PH_HALT;
                end
            endcase
        end
    end

    assign result.payload_byte  = payload_c;
    assign result.status        = status_c;
    assign result.fin_flag      = fin_reg;
    assign result.frame_opcode  = opcode_reg;
    assign result.frame_length  = length_next;
    assign result.last_of_frame = last_c;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_HDR0;
            fin_reg        <= 1'b0;
            opcode_reg     <= '0;
            length_reg     <= '0;
            byte_count_reg <= '0;
            sub_index_reg  <= '0;
        end
        else
        begin
            phase_reg      <= phase_next;
            fin_reg        <= fin_next;
            opcode_reg     <= opcode_next;
            length_reg     <= length_next;
            byte_count_reg <= byte_count_next;
            sub_index_reg  <= sub_index_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (key_write)
        begin
            mask_key_reg[sub_index_reg] <= item_byte;
        end
    end

    // halt is left only through reset
    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_HALT |=> phase_reg == PH_HALT)
        else $error("halt state left without reset");

    a_payload_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.status != wsd_pkg::ST_DATA |-> result.payload_byte == '0)
        else $error("payload byte set on a non-data result");

    a_end_halts: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.status != wsd_pkg::ST_DATA
            && result.status != wsd_pkg::ST_EMPTY |=> phase_reg == PH_HALT)
        else $error("close or error result did not halt");

    a_data_len: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_DATA |-> length_reg != '0 && byte_count_reg < length_reg)
        else $error("payload phase with count past length");

endmodule

// ----- design/wsd_out_stage.sv -----
// wsd_out_stage: result register in front of the result channel
// depends on wsd_pkg and wsd_result_if
`timescale 1ns / 1ps

module wsd_out_stage (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  wsd_pkg::result_t     result,
    output logic                 stall,
    wsd_result_if.source         res
);

    logic              valid_reg;
    logic              valid_next;
    wsd_pkg::result_t  result_reg;

    assign stall = valid_reg && !res.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (!stall)
        begin
            valid_next = load;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && !stall)
        begin
            result_reg <= result;
        end
    end

    assign res.valid         = valid_reg;
    assign res.payload_byte  = result_reg.payload_byte;
    assign res.status        = result_reg.status;
    assign res.fin_flag      = result_reg.fin_flag;
    assign res.frame_opcode  = result_reg.frame_opcode;
    assign res.frame_length  = result_reg.frame_length;
    assign res.last_of_frame = result_reg.last_of_frame;

endmodule

// ----- design/websocket_frame_deframer.sv -----
// websocket_frame_deframer: top level, client frame parsing and payload unmasking
// result path: an accepted byte is held in the input register, and its result is
//   written to the result register when the parse advances
// throughput: one byte per cycle, set by the single parse stage between the
//   input register and the result register; backpressure stalls both
// reset: rst_n clears all control state, max_payload returns to 256
// depends on wsd_pkg, wsd_if, wsd_in_stage, wsd_parser, wsd_out_stage
`timescale 1ns / 1ps

module websocket_frame_deframer (
    input  logic         clk,
    input  logic         rst_n,
    wsd_byte_if.sink     rx,
    wsd_result_if.source res,
    wsd_cfg_if.sink      cfg
);

    logic                        item_valid;
    logic [wsd_pkg::BYTE_W-1:0]  item_byte;
    logic                        stall;
    logic                        advance;
    logic                        result_valid;
    wsd_pkg::result_t            result;
    logic [wsd_pkg::LEN_W-1:0]   max_payload_reg;

    assign advance   = item_valid && !stall;
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_payload_reg <= wsd_pkg::MAX_PAYLOAD_RESET;
        end
        else if (cfg.valid)
        begin
            max_payload_reg <= cfg.max_payload;
        end
    end

    wsd_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx         (rx),
        .advance    (advance),
        .item_valid (item_valid),
        .item_byte  (item_byte)
    );

    wsd_parser u_parser (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (advance),
        .item_byte    (item_byte),
        .max_payload  (max_payload_reg),
        .result_valid (result_valid),
        .result       (result)
    );

    wsd_out_stage u_out_stage (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (result_valid),
        .result (result),
        .stall  (stall),
        .res    (res)
    );

endmodule
